// File: hw/rtl/stick_arming_state_machine_top_defines.svh
// Assertion macros used by the stick arming state machine top level.
`ifndef STICK_ARMING_STATE_MACHINE_TOP_DEFINES_SVH
`define STICK_ARMING_STATE_MACHINE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/sas_pkg.sv
// Types and constants shared by the stick arming state machine modules.
`timescale 1ns / 1ps

package sas_pkg;

  typedef enum logic [2:0] {
    ST_STANDBY  = 3'd0,
    ST_READY    = 3'd1,
    ST_BLOCKED  = 3'd2,
    ST_ARMED    = 3'd3,
    ST_FAILSAFE = 3'd4
  } state_t;

  typedef enum logic [2:0] {
    RC_NONE             = 3'd0,
    RC_ARMED            = 3'd1,
    RC_ALREADY_ARMED    = 3'd2,
    RC_FAILSAFE         = 3'd3,
    RC_BLOCKED          = 3'd4,
    RC_THROTTLE         = 3'd5,
    RC_DISARMED         = 3'd6,
    RC_ALREADY_DISARMED = 3'd7
  } reply_t;

  localparam logic [1:0] MODE_UPDATE  = 2'd0;
  localparam logic [1:0] MODE_ARM     = 2'd1;
  localparam logic [1:0] MODE_DISARM  = 2'd2;

  localparam logic [1:0] REG_THROTTLE_LIMIT = 2'd0;
  localparam logic [1:0] REG_ARM_RUDDER     = 2'd1;
  localparam logic [1:0] REG_DISARM_RUDDER  = 2'd2;
  localparam logic [1:0] REG_HOLD_TIME      = 2'd3;

  localparam logic [11:0] THROTTLE_LIMIT_RST = 12'd1100;
  localparam logic [11:0] ARM_RUDDER_RST     = 12'd1900;
  localparam logic [11:0] DISARM_RUDDER_RST  = 12'd1100;
  localparam logic [15:0] HOLD_TIME_RST      = 16'd1000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] throttle_value;
    logic [11:0] rudder_value;
    logic        failsafe_active;
    logic        preflight_ok;
    logic        force_disarm;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [11:0] throttle_limit;
    logic [11:0] arm_rudder_threshold;
    logic [11:0] disarm_rudder_threshold;
    logic [15:0] hold_time_ms;
  } cfg_t;

  typedef struct packed {
    state_t      state;
    logic [31:0] arm_stamp;
    logic [31:0] disarm_stamp;
  } ctx_t;

  typedef struct packed {
    state_t state;
    logic   accepted;
    reply_t reply;
  } result_t;

endpackage

// File: hw/rtl/stick_arming_state_machine_top.sv
// Top level of the stick-gesture arming state machine with its stream ports.
`timescale 1ns / 1ps
`include "stick_arming_state_machine_top_defines.svh"

// Flight arming controller driven by a stream of words, one result word per
// input word. The input word's tuser selects a periodic update, an arm request
// or a disarm request; the result gives the flight state after the word, an
// accept flag and a reply code. An update forces failsafe when the link flag is
// set, leaves standby or failsafe for ready-to-arm or preflight-blocked, and
// arms or disarms once a low-throttle rudder gesture has been held for the
// programmed number of milliseconds, timed from the word's timestamp with
// 32-bit wrapping arithmetic (a stamp of zero means no hold is running). The
// block takes one word per clock cycle while it is not stalled; a word is
// captured in an input register at the edge that accepts it, then decision
// logic whose longest path is a 32-bit subtract and compare feeds the result
// register, which holds the result until it is taken. Both registers hold under
// backpressure; while a finished result waits, the input register still takes
// one more word, and then the input side stalls until the result is taken. The
// four threshold registers are written through the cfg port and should only
// change while no word is in flight; they reset to throttle limit 1100, arm
// rudder 1900, disarm rudder 1100 and hold time 1000 ms.
module stick_arming_state_machine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // throttle_value[11:0], rudder_value[23:12], failsafe_active[24],
  // preflight_ok[25], force_disarm[26], now_ms[58:27], zero[63:59]
  input  logic [63:0] in_tdata,
  // mode[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // flight_state[2:0], accepted[3], reply_code[6:4], zero[7]
  output logic [7:0]  out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  // Control state.
  logic             in_vld_r;
  logic             out_vld_r;
  sas_pkg::ctx_t    ctx_r;
  sas_pkg::ctx_t    ctx_nxt;
  sas_pkg::cfg_t    cfg_r;

  // Payload registers.
  sas_pkg::item_t   item_r;
  sas_pkg::result_t res_r;
  sas_pkg::result_t res_nxt;

  logic adv;
  logic in_take;

  // The decision stage moves whenever the result register is free or drained.
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || adv;
  assign in_take   = in_tvalid && in_tready;

  sas_decide u_decide (
    .item    (item_r),
    .cfg     (cfg_r),
    .ctx     (ctx_r),
    .ctx_nxt (ctx_nxt),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      ctx_r.state        <= sas_pkg::ST_STANDBY;
      ctx_r.arm_stamp    <= '0;
      ctx_r.disarm_stamp <= '0;
      cfg_r.throttle_limit          <= sas_pkg::THROTTLE_LIMIT_RST;
      cfg_r.arm_rudder_threshold    <= sas_pkg::ARM_RUDDER_RST;
      cfg_r.disarm_rudder_threshold <= sas_pkg::DISARM_RUDDER_RST;
      cfg_r.hold_time_ms            <= sas_pkg::HOLD_TIME_RST;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (adv) begin
        out_vld_r <= in_vld_r;
      end
      if (in_vld_r && adv) begin
        ctx_r <= ctx_nxt;
      end
      if (cfg_we) begin
        case (cfg_addr)
          sas_pkg::REG_THROTTLE_LIMIT: cfg_r.throttle_limit          <= cfg_wdata[11:0];
          sas_pkg::REG_ARM_RUDDER:     cfg_r.arm_rudder_threshold    <= cfg_wdata[11:0];
          sas_pkg::REG_DISARM_RUDDER:  cfg_r.disarm_rudder_threshold <= cfg_wdata[11:0];
          sas_pkg::REG_HOLD_TIME:      cfg_r.hold_time_ms            <= cfg_wdata;
          default:                     cfg_r.hold_time_ms            <= cfg_r.hold_time_ms;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.mode            <= in_tuser;
      item_r.throttle_value  <= in_tdata[11:0];
      item_r.rudder_value    <= in_tdata[23:12];
      item_r.failsafe_active <= in_tdata[24];
      item_r.preflight_ok    <= in_tdata[25];
      item_r.force_disarm    <= in_tdata[26];
      item_r.now_ms          <= in_tdata[58:27];
    end
    if (in_vld_r && adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, res_r.reply, res_r.accepted, res_r.state};

  // A successful command always carries a reply code.
  `SAS_ASSERT_NOW(a_acc_has_code, out_vld_r && res_r.accepted,
                  res_r.reply != sas_pkg::RC_NONE, "accepted result without reply code")
  // A fresh arm lands in the armed state.
  `SAS_ASSERT_NOW(a_armed_reply, out_vld_r && res_r.reply == sas_pkg::RC_ARMED,
                  res_r.state == sas_pkg::ST_ARMED, "armed reply outside armed state")
  // Only the gesture of the current side may have a hold running.
  `SAS_ASSERT_NOW(a_stamp_side, 1'b1,
                  (ctx_r.state == sas_pkg::ST_ARMED) ? (ctx_r.arm_stamp == '0)
                                                     : (ctx_r.disarm_stamp == '0),
                  "hold stamp running on the wrong side")
  // A stalled decision stage must not touch the flight state.
  `SAS_ASSERT_NEXT(a_stall_holds, !adv, $stable(ctx_r), "state changed while stalled")

endmodule

// File: hw/rtl/sas_decide.sv
// Decision logic: applies one word to the flight state and hold stamps.
`timescale 1ns / 1ps

module sas_decide (
  input  sas_pkg::item_t   item,
  input  sas_pkg::cfg_t    cfg,
  input  sas_pkg::ctx_t    ctx,
  output sas_pkg::ctx_t    ctx_nxt,
  output sas_pkg::result_t res
);

  always_comb begin
    sas_pkg::state_t st;
    logic [31:0]     a;
    logic [31:0]     d;
    logic            acc;
    sas_pkg::reply_t code;
    logic            low_thr;
    logic [31:0]     elapsed;

    st      = ctx.state;
    a       = ctx.arm_stamp;
    d       = ctx.disarm_stamp;
    acc     = 1'b0;
    code    = sas_pkg::RC_NONE;
    low_thr = item.throttle_value < cfg.throttle_limit;
    elapsed = '0;

    case (item.mode)
      sas_pkg::MODE_UPDATE: begin
        if (item.failsafe_active) begin
          st = sas_pkg::ST_FAILSAFE; a = '0; d = '0;
        end else begin
          if (st == sas_pkg::ST_FAILSAFE || st == sas_pkg::ST_STANDBY) begin
            st = item.preflight_ok ? sas_pkg::ST_READY : sas_pkg::ST_BLOCKED;
            a  = '0;
            d  = '0;
          end
          if (st != sas_pkg::ST_ARMED) begin
            if (!item.preflight_ok) begin
              if (st != sas_pkg::ST_BLOCKED) begin
                st = sas_pkg::ST_BLOCKED; a = '0; d = '0;
              end
            end else begin
              if (st != sas_pkg::ST_READY) begin
                st = sas_pkg::ST_READY; a = '0; d = '0;
              end
              if (low_thr && item.rudder_value >= cfg.arm_rudder_threshold) begin
                if (a == '0) a = item.now_ms;
                elapsed = item.now_ms - a;
                if (elapsed >= {16'd0, cfg.hold_time_ms}) begin
                  st = sas_pkg::ST_ARMED; a = '0; d = '0;
                end
              end else begin
                a = '0;
              end
            end
          end else begin
            if (low_thr && item.rudder_value <= cfg.disarm_rudder_threshold) begin
              if (d == '0) d = item.now_ms;
              elapsed = item.now_ms - d;
              if (elapsed >= {16'd0, cfg.hold_time_ms}) begin
                st = sas_pkg::ST_READY; a = '0; d = '0;
              end
            end else begin
              d = '0;
            end
          end
        end
      end
      sas_pkg::MODE_ARM: begin
        if (st == sas_pkg::ST_ARMED) begin
          acc = 1'b1; code = sas_pkg::RC_ALREADY_ARMED;
        end else if (item.failsafe_active) begin
          code = sas_pkg::RC_FAILSAFE;
        end else if (!item.preflight_ok) begin
          code = sas_pkg::RC_BLOCKED;
          st = sas_pkg::ST_BLOCKED; a = '0; d = '0;
        end else if (!low_thr) begin
          code = sas_pkg::RC_THROTTLE;
        end else begin
          st = sas_pkg::ST_ARMED; a = '0; d = '0;
          acc = 1'b1; code = sas_pkg::RC_ARMED;
        end
      end
      sas_pkg::MODE_DISARM: begin
        if (st != sas_pkg::ST_ARMED) begin
          st = sas_pkg::ST_READY; a = '0; d = '0;
          acc = 1'b1; code = sas_pkg::RC_ALREADY_DISARMED;
        end else if (!item.force_disarm && !low_thr) begin
          code = sas_pkg::RC_THROTTLE;
        end else begin
          st = sas_pkg::ST_READY; a = '0; d = '0;
          acc = 1'b1; code = sas_pkg::RC_DISARMED;
        end
      end
      default: begin
        // The unused mode leaves everything as it is.
        acc = 1'b0;
      end
    endcase

    ctx_nxt.state        = st;
    ctx_nxt.arm_stamp    = a;
    ctx_nxt.disarm_stamp = d;
    res.state            = st;
    res.accepted         = acc;
    res.reply            = code;
  end

endmodule
